[src/mbrot_pkg.sv]
// shared types, constants and microcode program for the mandelbrot escape-time core
`default_nettype none

package mbrot_pkg;

	// default geometry
	localparam int COORD_BITS_DEF = 10;
	localparam int FRAC_BITS_DEF  = 28;

	// configuration port
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_ORIGIN    = 3'd0,
		REG_Y_TOP       = 3'd1,
		REG_X_STEP      = 3'd2,
		REG_Y_STEP      = 3'd3,
		REG_MAX_ITER    = 3'd4,
		REG_ITER_SHIFT  = 3'd5,
		REG_BLACK_COLOR = 3'd6
	} reg_idx_t;

	// register reset values
	localparam logic signed [31:0] X_ORIGIN_RST    = 32'sd72705713;
	localparam logic signed [31:0] Y_TOP_RST       = 32'sd1291175;
	localparam logic [27:0]        X_STEP_RST      = 28'd126;
	localparam logic [27:0]        Y_STEP_RST      = 28'd190;
	localparam logic [15:0]        MAX_ITER_RST    = 16'd1024;
	localparam logic [3:0]         ITER_SHIFT_RST  = 4'd4;
	localparam logic [15:0]        BLACK_COLOR_RST = 16'd0;

	// multiplier operand pair
	typedef enum logic [2:0] {
		MS_COL_XSTEP,
		MS_ROW_YSTEP,
		MS_UU,
		MS_VV,
		MS_UV
	} mul_sel_t;

	// product register written by the multiplier
	typedef enum logic [1:0] {
		MD_NONE,
		MD_UU,
		MD_VV,
		MD_UV
	} mul_dst_t;

	// datapath operation of a step
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_CRE,
		OP_CIM,
		OP_INIT,
		OP_ITER,
		OP_RESULT
	} op_t;

	// sequencing of a step
	typedef enum logic [2:0] {
		JMP_NEXT,
		JMP_ALWAYS,
		JMP_EXIT,
		JMP_HOLD_IN,
		JMP_HOLD_OUT
	} jmp_t;

	localparam int PC_W = 4;

	// step addresses
	localparam logic [PC_W-1:0] STEP_IDLE  = 4'd0;
	localparam logic [PC_W-1:0] STEP_MULX  = 4'd1;
	localparam logic [PC_W-1:0] STEP_CRE   = 4'd2;
	localparam logic [PC_W-1:0] STEP_CIM   = 4'd3;
	localparam logic [PC_W-1:0] STEP_INIT  = 4'd4;
	localparam logic [PC_W-1:0] STEP_LOOP  = 4'd5;
	localparam logic [PC_W-1:0] STEP_SQ_U  = 4'd6;
	localparam logic [PC_W-1:0] STEP_SQ_V  = 4'd7;
	localparam logic [PC_W-1:0] STEP_UV    = 4'd8;
	localparam logic [PC_W-1:0] STEP_DONE  = 4'd9;

	typedef struct packed {
		mul_sel_t        mul_sel;
		mul_dst_t        mul_dst;
		op_t             op;
		jmp_t            jmp;
		logic [PC_W-1:0] target;
	} ctrl_t;

	// microcode rom: one control word per step
	function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
		ctrl_t w;
		w = '{mul_sel: MS_UU, mul_dst: MD_NONE, op: OP_NONE, jmp: JMP_NEXT,
			target: STEP_IDLE};
		case (pc)
			STEP_IDLE: begin
				w.op  = OP_LOAD;
				w.jmp = JMP_HOLD_IN;
			end
			STEP_MULX: begin
				w.mul_sel = MS_COL_XSTEP;
				w.mul_dst = MD_UV;
			end
			STEP_CRE: begin
				w.op      = OP_CRE;
				w.mul_sel = MS_ROW_YSTEP;
				w.mul_dst = MD_UV;
			end
			STEP_CIM: begin
				w.op = OP_CIM;
			end
			STEP_INIT: begin
				w.op = OP_INIT;
			end
			STEP_LOOP: begin
				w.op     = OP_ITER;
				w.jmp    = JMP_EXIT;
				w.target = STEP_DONE;
			end
			STEP_SQ_U: begin
				w.mul_sel = MS_UU;
				w.mul_dst = MD_UU;
			end
			STEP_SQ_V: begin
				w.mul_sel = MS_VV;
				w.mul_dst = MD_VV;
			end
			STEP_UV: begin
				w.mul_sel = MS_UV;
				w.mul_dst = MD_UV;
				w.jmp     = JMP_ALWAYS;
				w.target  = STEP_LOOP;
			end
			STEP_DONE: begin
				w.op     = OP_RESULT;
				w.jmp    = JMP_HOLD_OUT;
				w.target = STEP_IDLE;
			end
			default: begin
				w.jmp    = JMP_ALWAYS;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (x < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[src/mandelbrot_escape_iteration_core.sv]
// Each iteration takes four microcode steps: the update and escape test, then three
// squares/products through the single 32x32 multiplier.
// One pixel is processed at a time; the result register frees the sequencer as soon as
// the output register is free (empty or being read).
// Reset (arst_n low, asynchronous) returns the sequencer to idle, drops out_valid and
// loads every configuration register with its reset value.
`default_nettype none

module mandelbrot_escape_iteration_core #(
	parameter int COORD_BITS = mbrot_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = mbrot_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                cfg_we,
	input  wire logic [mbrot_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [mbrot_pkg::CFG_DATA_W-1:0]    cfg_data,
	// pixel input
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [COORD_BITS-1:0]               pixel_col,
	input  wire logic [COORD_BITS-1:0]               pixel_row,
	// result output
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [15:0]                              iter_count,
	output logic                                     inside_res,
	output logic [15:0]                              color
);

	// width of the shifted squares and their sums
	localparam int SUM_W = 66 - FRAC_BITS;
	localparam logic signed [SUM_W-1:0] FOUR = SUM_W'(64'sd4 <<< FRAC_BITS);

	// configuration registers
	logic signed [31:0] x_origin_q;
	logic signed [31:0] y_top_q;
	logic [27:0]        x_step_q;
	logic [27:0]        y_step_q;
	logic [15:0]        max_iter_q;
	logic [3:0]         iter_shift_q;
	logic [15:0]        black_color_q;

	// sequencer
	logic [mbrot_pkg::PC_W-1:0] pc_q;
	logic [mbrot_pkg::PC_W-1:0] pc_nxt;
	mbrot_pkg::ctrl_t           ctrl;

	// datapath
	logic [COORD_BITS-1:0] col_q;
	logic [COORD_BITS-1:0] row_q;
	logic signed [31:0]    cre_q;
	logic signed [31:0]    cim_q;
	logic signed [31:0]    u_q;
	logic signed [31:0]    v_q;
	logic signed [63:0]    p_uu_q;
	logic signed [63:0]    p_vv_q;
	logic signed [63:0]    p_uv_q;
	logic [15:0]           k_q;

	logic signed [31:0]    mul_a;
	logic signed [31:0]    mul_b;
	logic signed [63:0]    mul_p;
	logic signed [SUM_W-1:0] u2;
	logic signed [SUM_W-1:0] v2;
	logic signed [SUM_W-1:0] uv2;
	logic signed [SUM_W-1:0] nu_w;
	logic signed [SUM_W-1:0] nv_w;
	logic signed [SUM_W-1:0] mag2;
	logic signed [31:0]    nu;
	logic signed [31:0]    nv;
	logic                  escaped;
	logic                  exit_loop;
	logic                  at_limit;

	// output register
	logic        out_valid_q;
	logic [15:0] iter_count_q;
	logic        inside_q;
	logic [15:0] color_q;

	logic in_xfer;
	logic out_free;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q    <= mbrot_pkg::X_ORIGIN_RST;
			y_top_q       <= mbrot_pkg::Y_TOP_RST;
			x_step_q      <= mbrot_pkg::X_STEP_RST;
			y_step_q      <= mbrot_pkg::Y_STEP_RST;
			max_iter_q    <= mbrot_pkg::MAX_ITER_RST;
			iter_shift_q  <= mbrot_pkg::ITER_SHIFT_RST;
			black_color_q <= mbrot_pkg::BLACK_COLOR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mbrot_pkg::REG_X_ORIGIN:    x_origin_q    <= $signed(cfg_data);
				mbrot_pkg::REG_Y_TOP:       y_top_q       <= $signed(cfg_data);
				mbrot_pkg::REG_X_STEP:      x_step_q      <= cfg_data[27:0];
				mbrot_pkg::REG_Y_STEP:      y_step_q      <= cfg_data[27:0];
				mbrot_pkg::REG_MAX_ITER:    max_iter_q    <= cfg_data[15:0];
				mbrot_pkg::REG_ITER_SHIFT:  iter_shift_q  <= cfg_data[3:0];
				mbrot_pkg::REG_BLACK_COLOR: black_color_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// control word of the current step
	assign ctrl     = mbrot_pkg::ucode_rom(pc_q);
	assign in_ready = (ctrl.jmp == mbrot_pkg::JMP_HOLD_IN);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// next step
	always_comb begin
		case (ctrl.jmp)
			mbrot_pkg::JMP_NEXT:     pc_nxt = pc_q + 1'b1;
			mbrot_pkg::JMP_ALWAYS:   pc_nxt = ctrl.target;
			mbrot_pkg::JMP_EXIT:     pc_nxt = exit_loop ? ctrl.target : pc_q + 1'b1;
			mbrot_pkg::JMP_HOLD_IN:  pc_nxt = in_xfer ? pc_q + 1'b1 : pc_q;
			mbrot_pkg::JMP_HOLD_OUT: pc_nxt = out_free ? ctrl.target : pc_q;
			default:                 pc_nxt = mbrot_pkg::STEP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= mbrot_pkg::STEP_IDLE;
		end else begin
			pc_q <= pc_nxt;
		end
	end

	// shared multiplier operand select
	always_comb begin
		case (ctrl.mul_sel)
			mbrot_pkg::MS_COL_XSTEP: begin
				mul_a = $signed(32'(col_q));
				mul_b = $signed(32'(x_step_q));
			end
			mbrot_pkg::MS_ROW_YSTEP: begin
				mul_a = $signed(32'(row_q));
				mul_b = $signed(32'(y_step_q));
			end
			mbrot_pkg::MS_UU: begin
				mul_a = u_q;
				mul_b = u_q;
			end
			mbrot_pkg::MS_VV: begin
				mul_a = v_q;
				mul_b = v_q;
			end
			mbrot_pkg::MS_UV: begin
				mul_a = u_q;
				mul_b = v_q;
			end
			default: begin
				mul_a = u_q;
				mul_b = v_q;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// floor-shifted squares and cross product, update and escape test
	assign u2        = SUM_W'(p_uu_q >>> FRAC_BITS);
	assign v2        = SUM_W'(p_vv_q >>> FRAC_BITS);
	assign uv2       = SUM_W'(p_uv_q >>> (FRAC_BITS - 1));
	assign nu_w      = u2 - v2 + SUM_W'(cre_q);
	assign nv_w      = uv2 + SUM_W'(cim_q);
	assign nu        = mbrot_pkg::sat32(64'(nu_w));
	assign nv        = mbrot_pkg::sat32(64'(nv_w));
	assign mag2      = u2 + v2;
	assign escaped   = (mag2 >= FOUR);
	assign exit_loop = (k_q >= max_iter_q) || escaped;
	assign at_limit  = (k_q >= max_iter_q);

	// product registers
	always_ff @(posedge clk) begin
		if (ctrl.op == mbrot_pkg::OP_INIT) begin
			p_uu_q <= '0;
			p_vv_q <= '0;
			p_uv_q <= '0;
		end else begin
			case (ctrl.mul_dst)
				mbrot_pkg::MD_UU: p_uu_q <= mul_p;
				mbrot_pkg::MD_VV: p_vv_q <= mul_p;
				mbrot_pkg::MD_UV: p_uv_q <= mul_p;
				default: ;
			endcase
		end
	end

	// datapath operations
	always_ff @(posedge clk) begin
		case (ctrl.op)
			mbrot_pkg::OP_LOAD: begin
				if (in_xfer) begin
					col_q <= pixel_col;
					row_q <= pixel_row;
				end
			end
			mbrot_pkg::OP_CRE: begin
				cre_q <= mbrot_pkg::sat32(64'(x_origin_q) + p_uv_q);
			end
			mbrot_pkg::OP_CIM: begin
				cim_q <= mbrot_pkg::sat32(64'(y_top_q) - p_uv_q);
			end
			mbrot_pkg::OP_INIT: begin
				u_q <= '0;
				v_q <= '0;
				k_q <= 16'd1;
			end
			mbrot_pkg::OP_ITER: begin
				if (!exit_loop) begin
					u_q <= nu;
					v_q <= nv;
					k_q <= k_q + 16'd1;
				end
			end
			default: ;
		endcase
	end

	// result payload
	always_ff @(posedge clk) begin
		if (ctrl.op == mbrot_pkg::OP_RESULT && out_free) begin
			iter_count_q <= k_q;
			inside_q     <= at_limit;
			color_q      <= at_limit ? black_color_q : (k_q >> iter_shift_q);
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.op == mbrot_pkg::OP_RESULT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign iter_count = iter_count_q;
	assign inside_res = inside_q;
	assign color      = color_q;

endmodule

`default_nettype wire

[src/mbrot_checker.sv]
// port-level checker for the mandelbrot escape-time core, bound to the top level
`default_nettype none

module mbrot_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] iter_count,
	input wire logic        inside_res,
	input wire logic [15:0] color
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(iter_count)
			&& $stable(inside_res) && $stable(color))
		else $error("result changed while stalled");

	// one pixel in flight: no new transfer right after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a pixel is in flight");

	// the counter starts at one
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> iter_count != 16'd0)
		else $error("iteration count of zero");

	// an escaped point's color, its shifted count, does not exceed the count
	a_color_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !inside_res |-> color <= iter_count)
		else $error("escaped color exceeds iteration count");

endmodule

bind mandelbrot_escape_iteration_core mbrot_checker u_mbrot_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.iter_count (iter_count),
	.inside_res (inside_res),
	.color      (color)
);

`default_nettype wire

[tb/sv/mandelbrot_escape_iteration_core_tb.sv]
// self-checking testbench for the mandelbrot escape-time core
`default_nettype none

module mandelbrot_escape_iteration_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_BITS   = mbrot_pkg::COORD_BITS_DEF;
	localparam int FRAC_BITS    = mbrot_pkg::FRAC_BITS_DEF;
	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 5;
	// longest quiet stretch: one pixel at the top iteration limit plus stalls
	localparam int WATCHDOG_LIMIT = 1000000;
	localparam int HOLD_CYCLES    = 3000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int RAND_PHASES    = 10;
	localparam int RAND_PER_PHASE = 56;
	localparam logic [mbrot_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
	} pixel_t;

	typedef struct packed {
		logic [15:0] iter_count;
		logic        in_set;
		logic [15:0] color;
	} escape_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [mbrot_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mbrot_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [COORD_BITS-1:0] pixel_col = '0;
	logic [COORD_BITS-1:0] pixel_row = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] iter_count;
	logic inside_res;
	logic [15:0] color;

	mandelbrot_escape_iteration_core #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_col (pixel_col),
		.pixel_row (pixel_row),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.iter_count(iter_count),
		.inside_res(inside_res),
		.color     (color)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// shadow copy of the configuration registers
	logic signed [31:0] view_x_origin   = mbrot_pkg::X_ORIGIN_RST;
	logic signed [31:0] view_y_top      = mbrot_pkg::Y_TOP_RST;
	logic [27:0]        view_x_step     = mbrot_pkg::X_STEP_RST;
	logic [27:0]        view_y_step     = mbrot_pkg::Y_STEP_RST;
	logic [15:0]        view_max_iter   = mbrot_pkg::MAX_ITER_RST;
	logic [3:0]         view_iter_shift = mbrot_pkg::ITER_SHIFT_RST;
	logic [15:0]        view_black      = mbrot_pkg::BLACK_COLOR_RST;

	pixel_t  pending_pixels[$];
	escape_t expected_escapes[$];
	int unsigned err_count = 0;
	logic src_idle_on = 1'b1;
	logic snk_idle_on = 1'b1;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int unsigned hold_cnt = 0;
	int unsigned src_gap = 0;
	int unsigned snk_gap = 0;
	int unsigned quiet_cycles = 0;

	function automatic longint clamp_word(input longint x);
		longint r;
		if (x > 64'sd2147483647) begin
			r = 64'sd2147483647;
		end else if (x < -64'sd2147483648) begin
			r = -64'sd2147483648;
		end else begin
			r = x;
		end
		return r;
	endfunction

	// escape-time iteration in fixed point, at the current register settings
	function automatic escape_t predict_escape(input pixel_t px);
		longint cre, cim, u, v, u2, v2, nu, nv, four;
		int unsigned k;
		escape_t r;
		cre = clamp_word(longint'(view_x_origin) + longint'(px.col) * longint'(view_x_step));
		cim = clamp_word(longint'(view_y_top) - longint'(px.row) * longint'(view_y_step));
		four = longint'(4) <<< FRAC_BITS;
		u = 0;
		v = 0;
		u2 = 0;
		v2 = 0;
		k = 1;
		while (k < view_max_iter && u2 + v2 < four) begin
			nv = clamp_word(((u * v) >>> (FRAC_BITS - 1)) + cim);
			nu = clamp_word(u2 - v2 + cre);
			u = nu;
			v = nv;
			u2 = (u * u) >>> FRAC_BITS;
			v2 = (v * v) >>> FRAC_BITS;
			k++;
		end
		r.iter_count = k[15:0];
		r.in_set = (k >= view_max_iter);
		r.color = r.in_set ? view_black : 16'(k >> view_iter_shift);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned want,
		input int unsigned got);
		$display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
		err_count++;
	endtask

	// idle length: mostly short, now and then long
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 3);
		end else if (r < 95) begin
			return $urandom_range(4, 16);
		end
		return $urandom_range(40, 300);
	endfunction

	// pixel driver: predicts each transfer, then offers the next queued pixel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pixel_col <= '0;
			pixel_row <= '0;
			src_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_escapes.push_back(predict_escape('{col: pixel_col, row: pixel_row}));
			end
			if (!in_valid || in_ready) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_pixels.size() != 0) begin
					in_valid <= 1'b1;
					pixel_col <= pending_pixels[0].col;
					pixel_row <= pending_pixels[0].row;
					void'(pending_pixels.pop_front());
					src_gap <= (src_idle_on && $urandom_range(0, 1) == 0) ? gap_len() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			snk_gap <= 0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_escapes.size() == 0) begin
					report_mismatch("unexpected result iter_count", 0, iter_count);
				end else begin
					if (iter_count !== expected_escapes[0].iter_count) begin
						report_mismatch("iter_count", expected_escapes[0].iter_count, iter_count);
					end
					if (inside_res !== expected_escapes[0].in_set) begin
						report_mismatch("inside_res", expected_escapes[0].in_set, inside_res);
					end
					if (color !== expected_escapes[0].color) begin
						report_mismatch("color", expected_escapes[0].color, color);
					end
					void'(expected_escapes.pop_front());
				end
			end
			if (hold_cnt != 0) begin
				hold_cnt <= hold_cnt - 1;
				out_ready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				hold_cnt <= HOLD_CYCLES;
				hold_done <= 1'b1;
				out_ready <= 1'b0;
			end else if (snk_gap != 0) begin
				snk_gap <= snk_gap - 1;
				out_ready <= 1'b0;
			end else if (snk_idle_on && $urandom_range(0, 7) == 0) begin
				snk_gap <= gap_len() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", quiet_cycles);
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic write_reg(input logic [mbrot_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			mbrot_pkg::REG_X_ORIGIN:    view_x_origin = data;
			mbrot_pkg::REG_Y_TOP:       view_y_top = data;
			mbrot_pkg::REG_X_STEP:      view_x_step = data[27:0];
			mbrot_pkg::REG_Y_STEP:      view_y_step = data[27:0];
			mbrot_pkg::REG_MAX_ITER:    view_max_iter = data[15:0];
			mbrot_pkg::REG_ITER_SHIFT:  view_iter_shift = data[3:0];
			mbrot_pkg::REG_BLACK_COLOR: view_black = data[15:0];
			default: ;
		endcase
	endtask

	task automatic queue_pixel(input int unsigned c, input int unsigned r);
		pending_pixels.push_back('{col: c[COORD_BITS-1:0], row: r[COORD_BITS-1:0]});
	endtask

	// wait until every queued pixel has produced its result, then let the core settle
	// (sampled on the falling edge so the driver's updates have landed)
	task automatic wait_drained();
		@(negedge clk);
		while (pending_pixels.size() != 0 || in_valid || expected_escapes.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: corners and alternating bit patterns
		queue_pixel(0, 0);
		queue_pixel(1023, 1023);
		queue_pixel(0, 1023);
		queue_pixel(1023, 0);
		queue_pixel(10'h2aa, 10'h155);
		queue_pixel(10'h155, 10'h2aa);
		queue_pixel(512, 300);
		wait_drained();

		// limit zero, then one: loop never runs
		write_reg(mbrot_pkg::REG_MAX_ITER, 32'h0000_0000);
		write_reg(mbrot_pkg::REG_BLACK_COLOR, 32'h0000_ffff);
		queue_pixel(3, 7);
		queue_pixel(1023, 1023);
		wait_drained();
		write_reg(mbrot_pkg::REG_MAX_ITER, 32'h0000_0001);
		write_reg(mbrot_pkg::REG_BLACK_COLOR, 32'h0000_5a5a);
		queue_pixel(0, 0);
		queue_pixel(700, 20);
		wait_drained();

		// point off the grid, saturated at both ends; widest steps and limit
		write_reg(mbrot_pkg::REG_X_ORIGIN, 32'h7fff_ffff);
		write_reg(mbrot_pkg::REG_Y_TOP, 32'h8000_0000);
		write_reg(mbrot_pkg::REG_X_STEP, 32'hffff_ffff);
		write_reg(mbrot_pkg::REG_Y_STEP, 32'hffff_ffff);
		write_reg(mbrot_pkg::REG_MAX_ITER, 32'h0000_ffff);
		write_reg(mbrot_pkg::REG_ITER_SHIFT, 32'h0000_0000);
		queue_pixel(1023, 1023);
		queue_pixel(0, 0);
		wait_drained();
		write_reg(mbrot_pkg::REG_X_ORIGIN, 32'h8000_0000);
		write_reg(mbrot_pkg::REG_Y_TOP, 32'h7fff_ffff);
		write_reg(mbrot_pkg::REG_ITER_SHIFT, 32'h0000_000f);
		queue_pixel(1023, 1023);
		queue_pixel(0, 0);
		queue_pixel(1, 0);
		wait_drained();

		// unknown register index leaves the settings alone
		write_reg(REG_UNUSED, $urandom);

		// top iteration limit: the origin stays inside, a far column escapes
		write_reg(mbrot_pkg::REG_X_ORIGIN, 32'h0000_0000);
		write_reg(mbrot_pkg::REG_Y_TOP, 32'h0000_0000);
		write_reg(mbrot_pkg::REG_X_STEP, 32'h0010_0000);
		write_reg(mbrot_pkg::REG_Y_STEP, 32'h0000_0000);
		write_reg(mbrot_pkg::REG_BLACK_COLOR, 32'h0000_0000);
		write_reg(mbrot_pkg::REG_ITER_SHIFT, 32'h0000_0004);
		queue_pixel(0, 5);
		queue_pixel(1023, 9);
		wait_drained();

		// random windows over the set, small limits for most phases
		for (int p = 0; p < RAND_PHASES; p++) begin
			if (p == RAND_PHASES - 1) begin
				write_reg(mbrot_pkg::REG_X_ORIGIN, $urandom);
				write_reg(mbrot_pkg::REG_Y_TOP, $urandom);
				write_reg(mbrot_pkg::REG_X_STEP, $urandom);
				write_reg(mbrot_pkg::REG_Y_STEP, $urandom);
			end else begin
				write_reg(mbrot_pkg::REG_X_ORIGIN, $urandom_range(0, 671088640) - 536870912);
				write_reg(mbrot_pkg::REG_Y_TOP, $urandom_range(0, 402653184));
				write_reg(mbrot_pkg::REG_X_STEP,
					{4'($urandom), 28'($urandom_range(0, 1 << 20))});
				write_reg(mbrot_pkg::REG_Y_STEP,
					{4'($urandom), 28'($urandom_range(0, 1 << 20))});
			end
			write_reg(mbrot_pkg::REG_MAX_ITER, {16'($urandom),
				(p % 3 == 0) ? 16'($urandom_range(100, 250)) : 16'($urandom_range(2, 60))});
			write_reg(mbrot_pkg::REG_ITER_SHIFT, $urandom);
			write_reg(mbrot_pkg::REG_BLACK_COLOR, $urandom);
			src_idle_on = ($urandom_range(0, 3) != 0);
			snk_idle_on = ($urandom_range(0, 3) != 0);
			if (p == 1) begin
				// long receiver stall while pixels keep coming
				hold_req <= 1'b1;
			end
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				queue_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
			end
			wait_drained();
		end

		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
